// File: hw/rtl/bfk_pkg.sv
// Shared types, codes and constants for the byte-key Bloom filter.
package bfk_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_NUM_WORDS  = 2'd0,
    REG_HASH_COUNT = 2'd1,
    REG_SPARE2     = 2'd2,
    REG_SPARE3     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT_SWEEP,
    ST_IDLE,
    ST_CLEAR_SWEEP,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  localparam logic [63:0] FNV_BASIS   = 64'd14695981039346656037;
  localparam logic [63:0] GOLDEN      = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] BASIS_TWO   = FNV_BASIS ^ GOLDEN;
  localparam int          BIT_SEL_W   = 6;
  localparam int          DIV_RADIX   = 4;
  localparam int          DIV_STEPS   = 15;
  localparam int          DIV_BITS    = DIV_RADIX * DIV_STEPS;
  localparam int          DIV_CW      = $clog2(DIV_STEPS);
  localparam int          NUM_WORDS_W = 11;
  localparam int          NUM_HASH_W  = 5;
  localparam logic [NUM_WORDS_W-1:0] NUM_WORDS_RST = 11'd1024;
  localparam logic [NUM_HASH_W-1:0]  NUM_HASH_RST  = 5'd7;

  typedef struct packed {
    logic hash_byte;
    logic key_end;
    logic div_step;
    logic ram_rd;
    logic probe_done;
    logic sweep_start;
    logic sweep_step;
    logic result_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_probe;
    logic sweep_done;
    logic out_free;
  } dp_stat_t;

  // FNV-1a step; prime 0x100000001b3 as shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: hw/rtl/bloom_filter_byte_keys_unit.sv
// Top level of the byte-key Bloom filter: controller, datapath and ports.
//  channel  | direction | request moves
//  s_axis   | in        | one key byte with command
//  m_axis   | out       | one completed operation
//  cfg      | in        | one register write (bitmap words, probe count)
// A key byte without the last mark leaves the unit ready for the next byte.
// A key end runs, per probe, the word divider, a bitmap read and a check
// that writes the bit back for an insert, then loads the result.
// Clear, and reset, sweep every word of the bitmap; no request is
// taken meanwhile. A waiting result stalls only the next operation's finish.
module bloom_filter_byte_keys_unit #(
  parameter int MAX_WORDS  = 1024,
  parameter int MAX_HASHES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser,   // [1:0] cmd, [2] byte_valid
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] maybe_present, [32:1] insert_total
  output logic [1:0]  m_axis_tuser,   // [1:0] done_cmd
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import bfk_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bfk_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .in_cmd        (s_axis_tuser[1:0]),
    .in_last       (s_axis_tlast),
    .stat          (stat),
    .s_axis_tready (s_axis_tready),
    .ctl           (ctl)
  );

  bfk_datapath #(.MAX_WORDS(MAX_WORDS), .MAX_HASHES(MAX_HASHES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .in_cmd        (s_axis_tuser[1:0]),
    .data_byte     (s_axis_tdata),
    .byte_valid    (s_axis_tuser[2]),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_init_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_axis_tready) else $error("request taken during init sweep");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == CMD_CLEAR) |=> !s_axis_tready)
    else $error("request taken during clear sweep");

  a_key_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast &&
     (s_axis_tuser[1:0] == CMD_INSERT || s_axis_tuser[1:0] == CMD_QUERY)) |=> !s_axis_tready)
    else $error("request taken during probes");

endmodule

// File: hw/rtl/bfk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bfk_ctrl.sv
// Controller state machine: sequences hashing, probes, sweeps and results.
module bfk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic [1:0]        in_cmd,
  input  logic              in_last,
  input  bfk_pkg::dp_stat_t stat,
  output logic              s_axis_tready,
  output bfk_pkg::ctl_cmd_t ctl
);
  import bfk_pkg::*;

  state_t state, state_next;
  cmd_t   cmd;
  logic   accept;

  assign cmd    = cmd_t'(in_cmd);
  assign accept = s_axis_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT_SWEEP: if (stat.sweep_done) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          priority if (cmd == CMD_CLEAR) state_next = ST_CLEAR_SWEEP;
          else if (cmd != CMD_NONE && in_last) state_next = ST_DIV;
          else state_next = ST_IDLE;
        end
      end
      ST_CLEAR_SWEEP: if (stat.sweep_done) state_next = ST_FINISH;
      ST_DIV:   if (stat.div_done) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = stat.last_probe ? ST_FINISH : ST_DIV;
      ST_FINISH: if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_INIT_SWEEP, ST_CLEAR_SWEEP: ctl.sweep_step = 1'b1;
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          ctl.sweep_start = (cmd == CMD_CLEAR);
          ctl.hash_byte   = (cmd == CMD_INSERT) || (cmd == CMD_QUERY);
          ctl.key_end     = ctl.hash_byte && in_last;
        end
      end
      ST_DIV:    ctl.div_step    = 1'b1;
      ST_READ:   ctl.ram_rd      = 1'b1;
      ST_CHECK:  ctl.probe_done  = 1'b1;
      ST_FINISH: ctl.result_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/bfk_datapath.sv
// Datapath: hash accumulators, probe generator, word divider, bitmap and result.
module bfk_datapath #(
  parameter int MAX_WORDS  = 1024,
  parameter int MAX_HASHES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bfk_pkg::ctl_cmd_t               ctl,
  output bfk_pkg::dp_stat_t               stat,
  input  logic [1:0]                      in_cmd,
  input  logic [7:0]                      data_byte,
  input  logic                            byte_valid,
  input  logic                            cfg_valid,
  input  logic [1:0]                      cfg_index,
  input  logic [bfk_pkg::NUM_WORDS_W-1:0] cfg_data,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,
  output logic [1:0]                      m_axis_tuser
);
  import bfk_pkg::*;

  localparam int AW = MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1;
  localparam int WW = $clog2(MAX_WORDS + 1);
  localparam int HW = $clog2(MAX_HASHES + 1);

  logic [NUM_WORDS_W-1:0] num_words;
  logic [NUM_HASH_W-1:0]  hash_count;
  logic [WW-1:0]          eff_words;
  logic [HW-1:0]          eff_hashes;

  logic [63:0] hash_one, hash_two, h1_new, h2_new;
  logic [63:0] probe, step, probe_nx;
  logic [HW-1:0] probe_idx;
  cmd_t        op;
  logic        all_set;
  logic [31:0] insert_count, count_nx;

  logic [DIV_BITS-1:0] div_q;
  logic [WW-1:0]       rem, rem_nx;
  logic [DIV_CW-1:0]   div_cnt;

  logic [AW-1:0] sweep_cnt;
  logic          sweeping;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata, ram_rdata, mask;
  logic          advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_words  <= NUM_WORDS_RST;
      hash_count <= NUM_HASH_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NUM_WORDS:  num_words  <= cfg_data;
        REG_HASH_COUNT: hash_count <= cfg_data[NUM_HASH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_words == '0) eff_words = WW'(1);
    else if (32'(num_words) > MAX_WORDS) eff_words = WW'(MAX_WORDS);
    else eff_words = WW'(num_words);
    if (hash_count == '0) eff_hashes = HW'(1);
    else if (32'(hash_count) > MAX_HASHES) eff_hashes = HW'(MAX_HASHES);
    else eff_hashes = HW'(hash_count);
  end

  assign h1_new   = byte_valid ? fnv_step(hash_one, data_byte) : hash_one;
  assign h2_new   = byte_valid ? fnv_step(hash_two, data_byte) : hash_two;
  assign probe_nx = probe + step;
  assign advance  = ctl.probe_done && !stat.last_probe;

  always_ff @(posedge clk) begin
    if (rst || ctl.sweep_start) begin
      hash_one <= FNV_BASIS;
      hash_two <= BASIS_TWO;
    end else if (ctl.key_end) begin
      hash_one <= FNV_BASIS;
      hash_two <= BASIS_TWO;
    end else if (ctl.hash_byte) begin
      hash_one <= h1_new;
      hash_two <= h2_new;
    end
  end

  // probe sequence and op latch
  always_ff @(posedge clk) begin
    if (ctl.key_end) begin
      probe     <= h1_new;
      step      <= h2_new | 64'd1;
      probe_idx <= '0;
      all_set   <= 1'b1;
    end else if (ctl.probe_done) begin
      if (op == CMD_QUERY && (ram_rdata & mask) == '0) all_set <= 1'b0;
      if (!stat.last_probe) begin
        probe     <= probe_nx;
        probe_idx <= probe_idx + HW'(1);
      end
    end
    if (ctl.key_end) op <= cmd_t'(in_cmd);
    else if (ctl.sweep_start) op <= CMD_CLEAR;
  end

  // word index = (probe >> 6) mod eff_words, radix-16 restoring
  always_comb begin
    logic [WW:0] t;
    rem_nx = rem;
    for (int j = 0; j < DIV_RADIX; j++) begin
      t = {rem_nx, div_q[DIV_BITS-1-j]};
      if (t >= {1'b0, eff_words}) t = t - {1'b0, eff_words};
      rem_nx = t[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.key_end || advance) begin
      div_q   <= DIV_BITS'(ctl.key_end ? h1_new[63:BIT_SEL_W] : probe_nx[63:BIT_SEL_W]);
      rem     <= '0;
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      div_q   <= div_q << DIV_RADIX;
      rem     <= rem_nx;
      div_cnt <= div_cnt + DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.sweep_start) begin
      sweep_cnt <= '0;
    end else if (ctl.sweep_step && !stat.sweep_done) begin
      sweep_cnt <= sweep_cnt + AW'(1);
    end
  end

  assign sweeping  = ctl.sweep_step;
  assign mask      = 64'd1 << probe[BIT_SEL_W-1:0];
  assign ram_we    = sweeping || (ctl.probe_done && op == CMD_INSERT);
  assign ram_waddr = sweeping ? sweep_cnt : AW'(rem);
  assign ram_wdata = sweeping ? '0 : (ram_rdata | mask);

  bfk_ram #(.WIDTH(64), .DEPTH(MAX_WORDS)) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.ram_rd),
    .raddr (AW'(rem)),
    .rdata (ram_rdata)
  );

  assign count_nx = (op == CMD_INSERT && insert_count != '1) ? insert_count + 32'd1
                                                             : insert_count;

  always_ff @(posedge clk) begin
    if (rst || ctl.sweep_start) begin
      insert_count <= '0;
    end else if (ctl.result_load) begin
      insert_count <= count_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.result_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (ctl.result_load) begin
      m_axis_tuser <= op;
      m_axis_tdata <= {7'd0, count_nx, (op == CMD_QUERY) && all_set};
    end
  end

  assign stat.div_done   = (div_cnt == DIV_CW'(DIV_STEPS - 1));
  assign stat.last_probe = (probe_idx == eff_hashes - HW'(1));
  assign stat.sweep_done = (sweep_cnt == AW'(MAX_WORDS - 1));
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

endmodule
